@@ design/three_band_crossover_filter_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the three-band crossover top level
// Implication and next-cycle checks, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_BAND_CROSSOVER_FILTER_TOP_ASSERT_SVH
`define THREE_BAND_CROSSOVER_FILTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define TBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crossover check failed");

// Consequent must hold in the cycle after the antecedent
`define TBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crossover check failed");

`endif

@@ design/tbc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared constants, types and saturation helpers of the crossover filter.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int CHANNELS       = 2;
  localparam int STATE_BITS     = 40;
  localparam int COEF_W         = 24;
  localparam int CFG_W          = 48;
  localparam int CFG_AW         = 3;
  localparam int SECT_WORDS     = 16;
  localparam int SUM_W          = 66;
  localparam int ACC_W          = 64;
  localparam int PART_W         = 20;
  localparam int PROD_W         = PART_W + 1 + COEF_W;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_LOW_DEN      = 3'd0;
  localparam logic [CFG_AW-1:0] REG_LOW_GAINS    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_HIGH_DEN     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_HIGH_GAINS   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_THREE_BAND   = 3'd4;

  localparam logic [2:0] SEC_LOW_HP_B  = 3'd3;
  localparam logic [2:0] SEC_LAST      = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PLO, ST_PHI, ST_Y, ST_F1LO, ST_F1HI, ST_F2LO, ST_F2HI,
    ST_WR1, ST_WR2, ST_DONE
  } state_t;

  typedef enum logic [1:0] {COEF_G, COEF_A1, COEF_A2} coef_sel_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       mul_hi;
    coef_sel_t  coef_sel;
    logic       opnd_y;
    logic       rd_en;
    logic       rd_k;
    logic       s1_en;
    logic       y_en;
    logic       f1_en;
    logic       wr1;
    logic       wr2;
    logic [2:0] sec;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic three_band;
  } sts_t;

  // Sign-extend a state word to the wide sum width
  function automatic logic signed [SUM_W-1:0] sx(input logic [STATE_BITS-1:0] v);
    return $signed({{(SUM_W-STATE_BITS){v[STATE_BITS-1]}}, v});
  endfunction

  // Clamp a wide sum to a signed state word
  function automatic logic [STATE_BITS-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] smax;
    logic signed [SUM_W-1:0] smin;
    smax = $signed({{(SUM_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}});
    smin = ~smax;
    if (v > smax) return smax[STATE_BITS-1:0];
    else if (v < smin) return smin[STATE_BITS-1:0];
    else return v[STATE_BITS-1:0];
  endfunction

endpackage

@@ design/three_band_crossover_filter_top.sv @@
// Three-band Linkwitz-Riley crossover for up to two audio channels. A sample
// and its channel go in on the in_ stream; one item with low, mid and high
// band samples comes out on the out_ stream. All biquad sections share one
// multiplier that forms each product in two passes. An item runs four
// sections in two-band mode and eight in three-band mode, plus any wait
// for the previous result to be taken. An item on a channel beyond the
// configured count gives zero bands. The user must load coefficients
// through cfg_ only while no item is in flight; it is not checked.
// ----------------------------------------------------------------------------
// three_band_crossover_filter_top
// Top level: sequencer, datapath and stream ports.
// ----------------------------------------------------------------------------
`include "three_band_crossover_filter_top_assert.svh"

module three_band_crossover_filter_top #(
  parameter int SAMPLE_BITS    = tbc_pkg::SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = tbc_pkg::COEF_FRAC_BITS,
  parameter int CHANNELS       = tbc_pkg::CHANNELS,
  parameter int IN_W           = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int OUT_W          = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_W-1:0]            in_tdata,   // sample
  input  logic                       in_tuser,   // channel
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_W-1:0]           out_tdata,  // low_band, mid_band, high_band
  output logic                       out_tuser,  // out_channel
  input  logic                       cfg_we,
  input  logic [tbc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [tbc_pkg::CFG_W-1:0]  cfg_wdata
);

  tbc_pkg::cmd_t cmd;
  tbc_pkg::sts_t sts;

  tbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  tbc_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CHANNELS       (CHANNELS),
    .OUT_W          (OUT_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_channel  (in_tuser),
    .in_sample   (in_tdata[SAMPLE_BITS-1:0]),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .out_channel (out_tuser),
    .out_bands   (out_tdata)
  );

  // Mid band slice of the result
  logic [SAMPLE_BITS-1:0] mid_band;
  assign mid_band = out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // Busy after a request is taken
  `TBC_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // Two-band results carry a silent mid band
  `TBC_ASSERT_IMP(a_two_band_mid, out_tvalid && !sts.three_band, mid_band == '0)
  // A fresh result appears only as the block returns to idle
  `TBC_ASSERT_IMP(a_result_idle, $rose(out_tvalid), in_tready)

endmodule

@@ design/tbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbc_ctrl
// Sequencer: steps each accepted sample through the biquad sections.
// ----------------------------------------------------------------------------
module tbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               out_tready,
  output logic               out_tvalid,
  input  tbc_pkg::sts_t      sts,
  output tbc_pkg::cmd_t      cmd
);

  tbc_pkg::state_t state_r, state_nxt;
  logic [2:0]      sec_r, sec_nxt;
  logic            out_vld_r, out_vld_nxt;

  assign in_tready  = (state_r == tbc_pkg::ST_IDLE);
  assign out_tvalid = out_vld_r;

  // Hold state, section counter and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tbc_pkg::ST_IDLE;
      sec_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sec_r     <= sec_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    sec_nxt      = sec_r;
    cmd          = '0;
    cmd.coef_sel = tbc_pkg::COEF_G;
    cmd.sec      = sec_r;
    unique case (state_r)
      tbc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          sec_nxt   = '0;
          state_nxt = sts.ch_ok ? tbc_pkg::ST_PLO : tbc_pkg::ST_DONE;
        end
      end
      tbc_pkg::ST_PLO: begin
        cmd.mul_en = 1'b1;
        cmd.rd_en  = 1'b1;
        state_nxt  = tbc_pkg::ST_PHI;
      end
      tbc_pkg::ST_PHI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_k   = 1'b1;
        cmd.s1_en  = 1'b1;
        state_nxt  = tbc_pkg::ST_Y;
      end
      tbc_pkg::ST_Y: begin
        cmd.y_en  = 1'b1;
        state_nxt = tbc_pkg::ST_F1LO;
      end
      tbc_pkg::ST_F1LO: begin
        cmd.mul_en   = 1'b1;
        cmd.opnd_y   = 1'b1;
        cmd.coef_sel = tbc_pkg::COEF_A1;
        state_nxt    = tbc_pkg::ST_F1HI;
      end
      tbc_pkg::ST_F1HI: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_hi   = 1'b1;
        cmd.opnd_y   = 1'b1;
        cmd.coef_sel = tbc_pkg::COEF_A1;
        state_nxt    = tbc_pkg::ST_F2LO;
      end
      tbc_pkg::ST_F2LO: begin
        cmd.f1_en    = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.opnd_y   = 1'b1;
        cmd.coef_sel = tbc_pkg::COEF_A2;
        state_nxt    = tbc_pkg::ST_F2HI;
      end
      tbc_pkg::ST_F2HI: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_hi   = 1'b1;
        cmd.opnd_y   = 1'b1;
        cmd.coef_sel = tbc_pkg::COEF_A2;
        state_nxt    = tbc_pkg::ST_WR1;
      end
      tbc_pkg::ST_WR1: begin
        cmd.wr1   = 1'b1;
        state_nxt = tbc_pkg::ST_WR2;
      end
      tbc_pkg::ST_WR2: begin
        cmd.wr2 = 1'b1;
        if (sec_r == tbc_pkg::SEC_LAST ||
            (sec_r == tbc_pkg::SEC_LOW_HP_B && !sts.three_band)) begin
          state_nxt = tbc_pkg::ST_DONE;
        end else begin
          sec_nxt   = sec_r + 3'd1;
          state_nxt = tbc_pkg::ST_PLO;
        end
      end
      tbc_pkg::ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          cmd.publish = 1'b1;
          state_nxt   = tbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbc_pkg::ST_IDLE;
    endcase
  end

  // Raise on publish, drop when taken
  always_comb begin
    if (cmd.publish) out_vld_nxt = 1'b1;
    else if (out_tready) out_vld_nxt = 1'b0;
    else out_vld_nxt = out_vld_r;
  end

endmodule

@@ design/tbc_dp.sv @@
// ----------------------------------------------------------------------------
// tbc_dp
// Datapath: coefficient registers, shared multiplier, delay memory and outputs.
// ----------------------------------------------------------------------------
module tbc_dp #(
  parameter int SAMPLE_BITS    = tbc_pkg::SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = tbc_pkg::COEF_FRAC_BITS,
  parameter int CHANNELS       = tbc_pkg::CHANNELS,
  parameter int OUT_W          = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tbc_pkg::cmd_t                 cmd,
  output tbc_pkg::sts_t                 sts,
  input  logic                          in_channel,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  input  logic                          cfg_we,
  input  logic [tbc_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [tbc_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_channel,
  output logic [OUT_W-1:0]              out_bands
);

  localparam int SB    = SAMPLE_BITS;
  localparam int SF    = tbc_pkg::STATE_BITS - 4 - SAMPLE_BITS;
  localparam int SW    = tbc_pkg::STATE_BITS;
  localparam int DEPTH = CHANNELS * tbc_pkg::SECT_WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = tbc_pkg::COEF_W;

  // Configuration registers
  logic [tbc_pkg::CFG_W-1:0] low_den_r, low_gain_r, high_den_r, high_gain_r;
  logic                      three_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_den_r   <= '0;
      low_gain_r  <= '0;
      high_den_r  <= '0;
      high_gain_r <= '0;
      three_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tbc_pkg::REG_LOW_DEN:    low_den_r   <= cfg_wdata;
        tbc_pkg::REG_LOW_GAINS:  low_gain_r  <= cfg_wdata;
        tbc_pkg::REG_HIGH_DEN:   high_den_r  <= cfg_wdata;
        tbc_pkg::REG_HIGH_GAINS: high_gain_r <= cfg_wdata;
        tbc_pkg::REG_THREE_BAND: three_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign sts.three_band = three_r;
  assign sts.ch_ok      = (int'(in_channel) < CHANNELS);

  // Sample registers
  logic          ch_r, zero_r;
  logic [SW-1:0] xin_r, x_r, y_r, s1_r, rd_r;
  logic [SW-1:0] low_r, hp1_r, mid_r, high_r;
  logic signed [tbc_pkg::SUM_W-1:0] p_r, f1_r, f2_r;
  logic signed [tbc_pkg::ACC_W-1:0] acc_r;
  logic [SW-1:0] x_scaled;

  assign x_scaled = SW'($signed({{(SW-SB){in_sample[SB-1]}}, in_sample}) <<< SF);

  // Coefficient select: upper crossover for sections four to seven
  logic [tbc_pkg::CFG_W-1:0] den, gains;
  logic signed [CW-1:0]      coef;
  logic                      hp;

  assign den   = cmd.sec[2] ? high_den_r : low_den_r;
  assign gains = cmd.sec[2] ? high_gain_r : low_gain_r;
  assign hp    = cmd.sec[1];

  always_comb begin
    unique case (cmd.coef_sel)
      tbc_pkg::COEF_G:  coef = hp ? $signed(gains[2*CW-1:CW]) : $signed(gains[CW-1:0]);
      tbc_pkg::COEF_A1: coef = $signed(den[CW-1:0]);
      tbc_pkg::COEF_A2: coef = $signed(den[2*CW-1:CW]);
      default:          coef = '0;
    endcase
  end

  // Shared multiplier, two passes per product: low half then high half
  logic [SW-1:0]                      opnd;
  logic signed [tbc_pkg::PART_W:0]    part;
  logic signed [tbc_pkg::PROD_W-1:0]  prod;
  logic signed [tbc_pkg::ACC_W-1:0]   prod_x;

  assign opnd   = cmd.opnd_y ? y_r : x_r;
  assign part   = cmd.mul_hi ? $signed({opnd[SW-1], opnd[SW-1:tbc_pkg::PART_W]})
                             : $signed({1'b0, opnd[tbc_pkg::PART_W-1:0]});
  assign prod   = part * coef;
  assign prod_x = $signed({{(tbc_pkg::ACC_W-tbc_pkg::PROD_W){prod[tbc_pkg::PROD_W-1]}}, prod});

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      acc_r <= cmd.mul_hi ? acc_r + (prod_x <<< tbc_pkg::PART_W) : prod_x;
    end
  end

  // Round the finished product to state scale, half toward plus infinity
  logic signed [tbc_pkg::SUM_W-1:0] acc_w, half, rnd;
  assign acc_w = $signed({{(tbc_pkg::SUM_W-tbc_pkg::ACC_W){acc_r[tbc_pkg::ACC_W-1]}}, acc_r});
  assign half  = $signed(tbc_pkg::SUM_W'(1)) <<< (COEF_FRAC_BITS - 1);
  assign rnd   = (acc_w + half) >>> COEF_FRAC_BITS;

  // Delay memory with per-word valid bits
  logic [SW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [AW-1:0]    rd_a, wr_a;
  logic [SW-1:0]    wr_d;
  logic             wr_en;
  logic signed [tbc_pkg::SUM_W-1:0] mid2;

  assign rd_a  = AW'({ch_r, cmd.sec, cmd.rd_k});
  assign wr_a  = AW'({ch_r, cmd.sec, cmd.wr2});
  assign wr_en = cmd.wr1 | cmd.wr2;
  assign mid2  = hp ? -(p_r <<< 1) : (p_r <<< 1);
  assign wr_d  = cmd.wr2 ? tbc_pkg::sat_state(p_r - f2_r)
                         : tbc_pkg::sat_state(mid2 - f1_r + tbc_pkg::sx(rd_r));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    if (cmd.rd_en) rd_r <= vld_r[rd_a] ? mem[rd_a] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (wr_en) vld_r[wr_a] <= 1'b1;
  end

  // Section arithmetic and routing between sections
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r   <= in_channel;
      zero_r <= !sts.ch_ok;
      xin_r  <= x_scaled;
      x_r    <= x_scaled;
    end
    if (cmd.s1_en) s1_r <= rd_r;
    if (cmd.y_en) begin
      p_r <= rnd;
      y_r <= tbc_pkg::sat_state(rnd + tbc_pkg::sx(s1_r));
    end
    if (cmd.f1_en) f1_r <= rnd;
    if (cmd.wr1) f2_r <= rnd;
    if (cmd.wr2) begin
      // next section starts from the raw input for sections two and six
      x_r <= (cmd.sec[0] && !cmd.sec[2] && !cmd.sec[1]) || (cmd.sec == 3'd5) ? xin_r : y_r;
      unique case (cmd.sec)
        3'd1:    low_r  <= y_r;
        3'd3:    hp1_r  <= y_r;
        3'd5:    mid_r  <= y_r;
        3'd7:    high_r <= y_r;
        default: ;
      endcase
    end
  end

  // Round a state value to an output band sample
  function automatic logic [SB-1:0] to_band(input logic [SW-1:0] y);
    logic signed [SW:0] t;
    logic signed [SW:0] hi;
    logic signed [SW:0] lo;
    t  = ($signed({y[SW-1], y}) + ($signed((SW+1)'(1)) <<< (SF - 1))) >>> SF;
    hi = ($signed((SW+1)'(1)) <<< (SB - 1)) - $signed((SW+1)'(1));
    lo = -hi - $signed((SW+1)'(1));
    if (t > hi) return hi[SB-1:0];
    else if (t < lo) return lo[SB-1:0];
    else return t[SB-1:0];
  endfunction

  // Output register
  logic [OUT_W-1:0] bands_nxt;

  always_comb begin
    bands_nxt = '0;
    if (!zero_r) begin
      bands_nxt[SB-1:0]      = to_band(low_r);
      bands_nxt[2*SB-1:SB]   = three_r ? to_band(mid_r) : '0;
      bands_nxt[3*SB-1:2*SB] = to_band(three_r ? high_r : hp1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_bands   <= bands_nxt;
      out_channel <= ch_r;
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Crossover filter testbench
// Streams samples through the three-band crossover and checks every band
// against a bit-exact predictor, over several coefficient and mode settings
// with and without random idling on both streams.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAC = tbc_pkg::STATE_BITS - 4 - tbc_pkg::SAMPLE_BITS;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic              ch;
    logic signed [23:0] smp;
  } sample_req_t;

  typedef struct packed {
    logic              ch;
    logic [23:0]       lo;
    logic [23:0]       mi;
    logic [23:0]       hi;
  } bands_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [tbc_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [tbc_pkg::CFG_W-1:0] cfg_wdata = '0;

  sample_req_t pending_samples[$];
  bands_t      expected_bands[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Predictor copy of registers and filter delays
  logic [47:0] p_low_den, p_low_gains, p_high_den, p_high_gains;
  logic        p_three;
  logic signed [63:0] delay_line[tbc_pkg::CHANNELS*tbc_pkg::SECT_WORDS];

  three_band_crossover_filter_top dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  always #5 clk = ~clk;

  function automatic logic signed [63:0] rshift_round(logic signed [63:0] v, int s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [63:0] clamp40(logic signed [63:0] v);
    if (v > 64'sd549755813887) return 64'sd549755813887;
    if (v < -64'sd549755813888) return -64'sd549755813888;
    return v;
  endfunction

  function automatic logic signed [63:0] coef(logic [47:0] r, bit upper);
    return upper ? 64'($signed(r[47:24])) : 64'($signed(r[23:0]));
  endfunction

  // Run one biquad; delay words at index w and w+1
  task automatic biquad(int w, inout logic signed [63:0] x, input logic signed [63:0] g,
                        input bit hp, input logic signed [63:0] a1, a2);
    logic signed [63:0] p, y, f1, f2;
    p = rshift_round(g * x, tbc_pkg::COEF_FRAC_BITS);
    y = clamp40(p + delay_line[w]);
    f1 = rshift_round(a1 * y, tbc_pkg::COEF_FRAC_BITS);
    f2 = rshift_round(a2 * y, tbc_pkg::COEF_FRAC_BITS);
    delay_line[w] = clamp40((hp ? -2 * p : 2 * p) - f1 + delay_line[w+1]);
    delay_line[w+1] = clamp40(p - f2);
    x = y;
  endtask

  task automatic biquad_pair(int w, inout logic signed [63:0] x, input logic [47:0] den,
                             input logic [47:0] gains, input bit hp);
    biquad(w, x, coef(gains, hp), hp, coef(den, 0), coef(den, 1));
    biquad(w + 2, x, coef(gains, hp), hp, coef(den, 0), coef(den, 1));
  endtask

  function automatic logic [23:0] band_out(logic signed [63:0] y);
    logic signed [63:0] v;
    v = rshift_round(y, FRAC);
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    return v[23:0];
  endfunction

  task automatic predict_bands(sample_req_t s);
    logic signed [63:0] x, lo, hp1, mi, hi;
    bands_t b;
    int base;
    base = int'(s.ch) * tbc_pkg::SECT_WORDS;
    x = 64'(s.smp) <<< FRAC;
    lo = x; hp1 = x;
    biquad_pair(base + 0, lo, p_low_den, p_low_gains, 0);
    biquad_pair(base + 4, hp1, p_low_den, p_low_gains, 1);
    b.ch = s.ch;
    b.lo = band_out(lo);
    b.mi = '0;
    if (p_three) begin
      mi = hp1; hi = x;
      biquad_pair(base + 8, mi, p_high_den, p_high_gains, 0);
      biquad_pair(base + 12, hi, p_high_den, p_high_gains, 1);
      b.mi = band_out(mi);
      b.hi = band_out(hi);
    end else begin
      b.hi = band_out(hp1);
    end
    expected_bands.push_back(b);
  endtask

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // Driver: present pending requests, predict on acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_bands(pending_samples.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_samples[0].smp;
          in_tuser <= pending_samples[0].ch;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare accepted results, drive back-pressure, watchdog
  always @(posedge clk) begin
    bands_t w;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no traffic");
        $display("** three_band_crossover_filter_top: FAILED **");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (expected_bands.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[23:0], 24'h0);
        end else begin
          w = expected_bands.pop_front();
          if (out_tuser !== w.ch) report_mismatch("channel", 24'(out_tuser), 24'(w.ch));
          if (out_tdata[23:0] !== w.lo) report_mismatch("low", out_tdata[23:0], w.lo);
          if (out_tdata[47:24] !== w.mi) report_mismatch("mid", out_tdata[47:24], w.mi);
          if (out_tdata[71:48] !== w.hi) report_mismatch("high", out_tdata[71:48], w.hi);
        end
      end
    end
  end

  task automatic write_reg(logic [tbc_pkg::CFG_AW-1:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbc_pkg::REG_LOW_DEN:    p_low_den = val;
      tbc_pkg::REG_LOW_GAINS:  p_low_gains = val;
      tbc_pkg::REG_HIGH_DEN:   p_high_den = val;
      tbc_pkg::REG_HIGH_GAINS: p_high_gains = val;
      tbc_pkg::REG_THREE_BAND: p_three = val[0];
      default: ;
    endcase
  endtask

  // Hold until every request is taken and every result has arrived
  task automatic drain;
    while (pending_samples.size() != 0 || in_tvalid || expected_bands.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [23:0] q22(real v);
    return 24'($rtoi(v * 4194304.0));
  endfunction

  // Stable Butterworth pair: gains for LP and HP, feedback a1,a2
  task automatic load_xover(bit upper, real a1, real a2, real glp, real ghp);
    write_reg(upper ? tbc_pkg::REG_HIGH_DEN : tbc_pkg::REG_LOW_DEN, {q22(a2), q22(a1)});
    write_reg(upper ? tbc_pkg::REG_HIGH_GAINS : tbc_pkg::REG_LOW_GAINS,
              {q22(ghp), q22(glp)});
  endtask

  task automatic push_sample(logic ch, logic [23:0] v);
    sample_req_t s;
    s.ch = ch; s.smp = v;
    pending_samples.push_back(s);
  endtask

  // Random audio: mostly sine-ish bursts, some full-scale noise
  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) push_sample(1'($urandom_range(1)), 24'($urandom));
      else push_sample(1'($urandom_range(1)), 24'($rtoi(8000000.0 * $sin(i * 0.3))
                                          + $signed(24'($urandom_range(20000))) - 10000));
    end
  endtask

  initial begin
    p_low_den = '0; p_low_gains = '0; p_high_den = '0; p_high_gains = '0; p_three = 1'b0;
    foreach (delay_line[i]) delay_line[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero coefficients, then crossover settings, extremes and channels
    send_idle_pct = 25; recv_idle_pct = 62;
    push_sample(0, 24'h7fffff); push_sample(1, 24'h800000);
    drain();
    load_xover(0, -1.56, 0.64, 0.02, 0.8);
    load_xover(1, -0.5, 0.2, 0.17, 0.43);
    write_reg(3'd5, 48'hffff_ffff_ffff);
    write_reg(3'd7, 48'h1234_5678_9abc);
    push_sample(0, 24'h000000); push_sample(0, 24'h7fffff); push_sample(1, 24'h800000);
    push_sample(1, 24'hffffff); push_sample(0, 24'h000001); push_sample(0, 24'h800000);
    for (int i = 0; i < 6; i++) push_sample(i[0], i[1] ? 24'h7fffff : 24'h800000);
    drain();
    write_reg(tbc_pkg::REG_THREE_BAND, 48'h1);
    for (int i = 0; i < 10; i++) push_sample(i[0], i[1] ? 24'h7fffff : 24'h800000);
    drain();

    // Extreme coefficients: overflow and saturation everywhere
    write_reg(tbc_pkg::REG_LOW_DEN, 48'h800000_800000);
    write_reg(tbc_pkg::REG_LOW_GAINS, 48'h7fffff_7fffff);
    write_reg(tbc_pkg::REG_HIGH_DEN, 48'h7fffff_7fffff);
    write_reg(tbc_pkg::REG_HIGH_GAINS, 48'h800000_800000);
    push_random(150);
    drain();

    // Random coefficient words, two-band
    write_reg(tbc_pkg::REG_THREE_BAND, 48'h0);
    write_reg(tbc_pkg::REG_LOW_DEN, {$urandom, $urandom});
    write_reg(tbc_pkg::REG_LOW_GAINS, {$urandom, $urandom});
    write_reg(tbc_pkg::REG_HIGH_DEN, {$urandom, $urandom});
    write_reg(tbc_pkg::REG_HIGH_GAINS, {$urandom, $urandom});
    push_random(150);
    drain();

    // Realistic crossover, three-band, idling swapped
    send_idle_pct = 62; recv_idle_pct = 25;
    load_xover(0, -1.9, 0.905, 0.0013, 0.95);
    load_xover(1, -1.1, 0.4, 0.075, 0.62);
    write_reg(tbc_pkg::REG_THREE_BAND, 48'h1);
    push_random(400);
    drain();

    // No idling, two-band then three-band
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(tbc_pkg::REG_THREE_BAND, 48'h0);
    push_random(250);
    drain();
    write_reg(tbc_pkg::REG_THREE_BAND, 48'h1);
    push_random(250);
    drain();

    if (errors == 0) $display("** three_band_crossover_filter_top: PASSED **");
    else $display("** three_band_crossover_filter_top: FAILED **");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/tbc_pkg.sv
design/tbc_ctrl.sv
design/tbc_dp.sv
design/three_band_crossover_filter_top.sv
verif/testbench.sv
